// File: hw/rtl/text_console_writer_unit_defines.svh
// ---------------------------------------------------------------------------
// text_console_writer_unit_defines
// Assertion macros for the text console writer.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define TCW_ASSERT_R(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define TCW_ASSERT(label, clk, rst, prop)
`define TCW_ASSERT_R(label, clk, prop)
`endif
`endif

// File: hw/rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] DEFAULT_ATTR = 8'h07;

   localparam logic [3:0] OP_PUT   = 4'd0;
   localparam logic [3:0] OP_BKSP  = 4'd1;
   localparam logic [3:0] OP_UP    = 4'd2;
   localparam logic [3:0] OP_DOWN  = 4'd3;
   localparam logic [3:0] OP_LEFT  = 4'd4;
   localparam logic [3:0] OP_RIGHT = 4'd5;
   localparam logic [3:0] OP_SET   = 4'd6;
   localparam logic [3:0] OP_CLEAR = 4'd7;
   localparam logic [3:0] OP_SUP   = 4'd8;
   localparam logic [3:0] OP_SDN   = 4'd9;
   localparam logic [3:0] OP_WRITE = 4'd10;
   localparam logic [3:0] OP_READ  = 4'd11;

   // classified command passed from front to back
   typedef struct packed {
      logic [3:0] func;
      logic [7:0] char_code;
      logic [7:0] col_x;
      logic [7:0] row_y;
      logic [7:0] cell_attr;
      logic       in_range;
   } cmd_type;
endpackage

// File: hw/rtl/tcw_ram.sv
// ---------------------------------------------------------------------------
// tcw_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/tcw_front.sv
// ---------------------------------------------------------------------------
// tcw_front
// Accept commands, check the target range and queue them (two entries).
// ---------------------------------------------------------------------------
module tcw_front #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [3:0]       func,
   input  logic [7:0]       char_code,
   input  logic [7:0]       col_x,
   input  logic [7:0]       row_y,
   input  logic [7:0]       cell_attr,
   output logic             full,
   output logic             q_valid,
   output tcw_pkg::cmd_type q_cmd,
   input  logic             pop
);
   tcw_pkg::cmd_type q_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   tcw_pkg::cmd_type cmd;

   // classify the incoming transaction
   always_comb begin
      cmd.func      = func;
      cmd.char_code = char_code;
      cmd.col_x     = col_x;
      cmd.row_y     = row_y;
      cmd.cell_attr = cell_attr;
      cmd.in_range  = (32'(col_x) < COLUMNS) && (32'(row_y) < ROWS);
   end

   // advance pointers and count
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cmd;
   end

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = q_ff[rp_ff];
endmodule

// File: hw/rtl/tcw_back.sv
// ---------------------------------------------------------------------------
// tcw_back
// Execute queued commands against the screen store and the cursor.
// ---------------------------------------------------------------------------
module tcw_back #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int AW     = $clog2(CELLS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       text_attr,
   input  logic             q_valid,
   input  tcw_pkg::cmd_type q_cmd,
   output logic             pop,
   output logic             idle,
   output logic             rsp_valid,
   output logic [7:0]       rsp_cell_char,
   output logic [7:0]       rsp_cell_attr_out,
   output logic [6:0]       rsp_cursor_col,
   output logic [4:0]       rsp_cursor_row,
   output logic [10:0]      rsp_cursor_linear
);
   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_MVRD = 3'd3;
   localparam logic [2:0] ST_MVWR = 3'd4;
   localparam logic [2:0] ST_FILL = 3'd5;
   localparam logic [2:0] ST_RESP = 3'd6;

   localparam logic [AW-1:0] LAST  = AW'(CELLS - 1);
   localparam logic [AW-1:0] COLS  = AW'(COLUMNS);
   localparam logic [AW-1:0] LROW  = AW'(CELLS - COLUMNS);
   localparam logic [7:0]    CMAX  = 8'(COLUMNS - 1);
   localparam logic [7:0]    RMAX  = 8'(ROWS - 1);

   logic [2:0]    st_ff, st_in;
   logic [7:0]    col_ff, col_in, row_ff, row_in;
   logic [AW-1:0] lin_ff, lin_in;
   logic [AW-1:0] ptr_ff, ptr_in, end_ff, end_in;
   logic          dn_ff, dn_in;
   logic [7:0]    rc_ff, rc_in, ra_ff, ra_in;
   logic          rdop_ff, rdop_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;
   logic [AW-1:0] tgt;
   logic [15:0]   blank;

   tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign tgt   = AW'(32'(q_cmd.row_y) * COLUMNS) + AW'(q_cmd.col_x);
   assign blank = {text_attr, tcw_pkg::BLANK_CHAR};

   // sequence commands, sweeps and the store clearing pass
   always_comb begin
      st_in   = st_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      lin_in  = lin_ff;
      ptr_in  = ptr_ff;
      end_in  = end_ff;
      dn_in   = dn_ff;
      rc_in   = rc_ff;
      ra_in   = ra_ff;
      rdop_in = rdop_ff;
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = blank;
      rd_addr = tgt;
      pop     = 1'b0;
      unique case (st_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = {tcw_pkg::DEFAULT_ATTR, tcw_pkg::BLANK_CHAR};
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == LAST) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               rc_in   = '0;
               ra_in   = '0;
               rdop_in = 1'b0;
               st_in   = ST_RESP;
               case (q_cmd.func)
                  tcw_pkg::OP_PUT: begin
                     if (q_cmd.char_code != tcw_pkg::NEWLINE_CHAR) begin
                        wr_en   = 1'b1;
                        wr_addr = lin_ff;
                        wr_data = {text_attr, q_cmd.char_code};
                     end
                     if (q_cmd.char_code != tcw_pkg::NEWLINE_CHAR && col_ff != CMAX) begin
                        col_in = col_ff + 1'b1;
                        lin_in = lin_ff + 1'b1;
                     end else if (row_ff != RMAX) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                        lin_in = lin_ff - AW'(col_ff) + COLS;
                     end else begin
                        col_in = '0;
                        lin_in = LROW;
                        ptr_in = '0;
                        end_in = LROW;
                        dn_in  = 1'b0;
                        st_in  = ST_MVRD;
                     end
                  end
                  tcw_pkg::OP_BKSP: begin
                     if (col_ff != 0 || row_ff != 0) begin
                        wr_en   = 1'b1;
                        wr_addr = lin_ff - 1'b1;
                        lin_in  = lin_ff - 1'b1;
                        if (col_ff != 0) col_in = col_ff - 1'b1;
                        else begin
                           col_in = CMAX;
                           row_in = row_ff - 1'b1;
                        end
                     end
                  end
                  tcw_pkg::OP_UP: begin
                     if (row_ff != 0) begin
                        row_in = row_ff - 1'b1;
                        lin_in = lin_ff - COLS;
                     end
                  end
                  tcw_pkg::OP_DOWN: begin
                     if (row_ff != RMAX) begin
                        row_in = row_ff + 1'b1;
                        lin_in = lin_ff + COLS;
                     end
                  end
                  tcw_pkg::OP_LEFT: begin
                     if (col_ff != 0) begin
                        col_in = col_ff - 1'b1;
                        lin_in = lin_ff - 1'b1;
                     end else if (row_ff != 0) begin
                        col_in = CMAX;
                        row_in = row_ff - 1'b1;
                        lin_in = lin_ff - 1'b1;
                     end
                  end
                  tcw_pkg::OP_RIGHT: begin
                     if (col_ff != CMAX) begin
                        col_in = col_ff + 1'b1;
                        lin_in = lin_ff + 1'b1;
                     end else if (row_ff != RMAX) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                        lin_in = lin_ff + 1'b1;
                     end
                  end
                  tcw_pkg::OP_SET: begin
                     if (q_cmd.in_range) begin
                        col_in = q_cmd.col_x;
                        row_in = q_cmd.row_y;
                        lin_in = tgt;
                     end
                  end
                  tcw_pkg::OP_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                     lin_in = '0;
                     ptr_in = '0;
                     end_in = LAST;
                     st_in  = ST_FILL;
                  end
                  tcw_pkg::OP_SUP: begin
                     ptr_in = '0;
                     end_in = LROW;
                     dn_in  = 1'b0;
                     st_in  = ST_MVRD;
                  end
                  tcw_pkg::OP_SDN: begin
                     ptr_in = LROW - 1'b1;
                     dn_in  = 1'b1;
                     st_in  = ST_MVRD;
                  end
                  tcw_pkg::OP_WRITE: begin
                     if (q_cmd.in_range) begin
                        wr_en   = 1'b1;
                        wr_addr = tgt;
                        wr_data = {q_cmd.cell_attr, q_cmd.char_code};
                     end
                  end
                  tcw_pkg::OP_READ: begin
                     rdop_in = 1'b1;
                     if (q_cmd.in_range) st_in = ST_RD;
                     else begin
                        rc_in = tcw_pkg::BLANK_CHAR;
                        ra_in = tcw_pkg::DEFAULT_ATTR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            rc_in = rd_data[7:0];
            ra_in = rd_data[15:8];
            st_in = ST_RESP;
         end
         // fetch source cell of a move
         ST_MVRD: begin
            rd_addr = dn_ff ? ptr_ff : ptr_ff + COLS;
            st_in   = ST_MVWR;
         end
         ST_MVWR: begin
            wr_en   = 1'b1;
            wr_addr = dn_ff ? ptr_ff + COLS : ptr_ff;
            wr_data = rd_data;
            st_in   = ST_MVRD;
            if (dn_ff) begin
               ptr_in = ptr_ff - 1'b1;
               // blank the top row from its first cell
               if (ptr_ff == 0) begin
                  ptr_in = '0;
                  end_in = COLS - 1'b1;
                  st_in  = ST_FILL;
               end
            end else begin
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff == LROW - 1'b1) begin
                  end_in = LAST;
                  st_in  = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == end_ff) st_in = ST_RESP;
         end
         ST_RESP: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_INIT;
         col_ff <= '0;
         row_ff <= '0;
         lin_ff <= '0;
         ptr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         col_ff <= col_in;
         row_ff <= row_in;
         lin_ff <= lin_in;
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff  <= end_in;
      dn_ff   <= dn_in;
      rc_ff   <= rc_in;
      ra_ff   <= ra_in;
      rdop_ff <= rdop_in;
   end

   assign idle              = (st_ff == ST_IDLE);
   assign rsp_valid         = (st_ff == ST_RESP);
   assign rsp_cell_char     = rdop_ff ? rc_ff : 8'h00;
   assign rsp_cell_attr_out = rdop_ff ? ra_ff : 8'h00;
   assign rsp_cursor_col    = col_ff[6:0];
   assign rsp_cursor_row    = row_ff[4:0];
   assign rsp_cursor_linear = 11'(lin_ff);
endmodule

// File: hw/rtl/text_console_writer_unit.sv
// ---------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: screen store, cursor, put/move/scroll/clear commands.
// ---------------------------------------------------------------------------
// One command at a time; each yields one rsp_valid pulse the receiver must
// take. Scrolls and clear run through the single store write port. After
// reset a clearing pass over all COLUMNS*ROWS cells runs before the first
// command is executed.
`include "text_console_writer_unit_defines.svh"
module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_func,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_col_x,
   input  logic [7:0]  req_row_y,
   input  logic [7:0]  req_cell_attr,
   output logic        rsp_valid,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_attr_out,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_linear,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_text_attr
);
   logic             full, q_valid, pop, idle, push;
   tcw_pkg::cmd_type q_cmd;
   logic [7:0]       attr_ff;

   assign busy      = full;
   assign push      = start && !full;
   assign csr_ready = 1'b1;

   // hold the current attribute
   always_ff @(posedge clock) begin
      if (reset) attr_ff <= tcw_pkg::DEFAULT_ATTR;
      else if (csr_valid) attr_ff <= csr_text_attr;
   end

   tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .clock, .reset, .push,
      .func(req_func), .char_code(req_char_code), .col_x(req_col_x),
      .row_y(req_row_y), .cell_attr(req_cell_attr),
      .full, .q_valid, .q_cmd, .pop
   );

   tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock, .reset, .text_attr(attr_ff), .q_valid, .q_cmd, .pop, .idle,
      .rsp_valid, .rsp_cell_char, .rsp_cell_attr_out, .rsp_cursor_col,
      .rsp_cursor_row, .rsp_cursor_linear
   );

   `TCW_ASSERT(a_pop_idle, clock, reset, pop |-> idle)
   `TCW_ASSERT(a_pop_busy, clock, reset, pop |=> !idle)
   `TCW_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   `TCW_ASSERT_R(a_reset_idle, clock, reset |=> !rsp_valid)
endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer: drives commands, keeps a
// shadow screen and cursor, and compares every response field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
   localparam int NCOL = tcw_pkg::COLUMNS_DEF;
   localparam int NROW = tcw_pkg::ROWS_DEF;
   localparam int NCELL = NCOL * NROW;
   localparam int SCROLL_CYC = 2 * NCOL * (NROW - 1) + NCOL + 3;
   localparam logic [3:0] OP_SPARE = 4'd15;

   typedef struct packed {
      logic [7:0]  ch;
      logic [7:0]  attr;
      logic [6:0]  col;
      logic [4:0]  row;
      logic [10:0] lin;
   } rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_func = '0;
   logic [7:0]  req_char_code = '0;
   logic [7:0]  req_col_x = '0;
   logic [7:0]  req_row_y = '0;
   logic [7:0]  req_cell_attr = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_cell_char;
   logic [7:0]  rsp_cell_attr_out;
   logic [6:0]  rsp_cursor_col;
   logic [4:0]  rsp_cursor_row;
   logic [10:0] rsp_cursor_linear;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_text_attr = '0;

   // shadow console state
   logic [15:0] shadow_screen [NCELL];
   int          cur_col;
   int          cur_row;
   logic [7:0]  cur_attr;
   rsp_t        expected_rsp [$];
   int          err_count = 0;
   int          cmd_count = 0;
   int          rsp_count = 0;

   text_console_writer_unit u_dut (.*);

   always #6 clock = ~clock;

   initial begin
      #150ms;
      $display("Timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

   // ---- console prediction ----
   function automatic void blank_line(int r);
      for (int x = 0; x < NCOL; x++)
         shadow_screen[r * NCOL + x] = {cur_attr, tcw_pkg::BLANK_CHAR};
   endfunction

   function automatic void shift_up();
      for (int i = 0; i < NCOL * (NROW - 1); i++) shadow_screen[i] = shadow_screen[i + NCOL];
      blank_line(NROW - 1);
   endfunction

   function automatic void shift_down();
      for (int i = NCELL - 1; i >= NCOL; i--) shadow_screen[i] = shadow_screen[i - NCOL];
      blank_line(0);
   endfunction

   function automatic void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= NROW) begin
         shift_up();
         cur_row = NROW - 1;
      end
   endfunction

   function automatic rsp_t console_predict(logic [3:0] f, logic [7:0] c, logic [7:0] x,
                                            logic [7:0] y, logic [7:0] a);
      rsp_t r;
      bit   ok;
      ok = (int'(x) < NCOL) && (int'(y) < NROW);
      r = '0;
      case (f)
         tcw_pkg::OP_PUT: begin
            if (c == tcw_pkg::NEWLINE_CHAR) line_feed();
            else begin
               shadow_screen[cur_row * NCOL + cur_col] = {cur_attr, c};
               cur_col++;
               if (cur_col >= NCOL) line_feed();
            end
         end
         tcw_pkg::OP_BKSP: begin
            if (cur_col > 0) begin
               cur_col--;
               shadow_screen[cur_row * NCOL + cur_col] = {cur_attr, tcw_pkg::BLANK_CHAR};
            end else if (cur_row > 0) begin
               cur_row--;
               cur_col = NCOL - 1;
               shadow_screen[cur_row * NCOL + cur_col] = {cur_attr, tcw_pkg::BLANK_CHAR};
            end
         end
         tcw_pkg::OP_UP: if (cur_row > 0) cur_row--;
         tcw_pkg::OP_DOWN: if (cur_row < NROW - 1) cur_row++;
         tcw_pkg::OP_LEFT: begin
            if (cur_col > 0) cur_col--;
            else if (cur_row > 0) begin
               cur_row--;
               cur_col = NCOL - 1;
            end
         end
         tcw_pkg::OP_RIGHT: begin
            if (cur_col < NCOL - 1) cur_col++;
            else if (cur_row < NROW - 1) begin
               cur_row++;
               cur_col = 0;
            end
         end
         tcw_pkg::OP_SET: if (ok) begin
            cur_col = int'(x);
            cur_row = int'(y);
         end
         tcw_pkg::OP_CLEAR: begin
            for (int i = 0; i < NROW; i++) blank_line(i);
            cur_col = 0;
            cur_row = 0;
         end
         tcw_pkg::OP_SUP: shift_up();
         tcw_pkg::OP_SDN: shift_down();
         tcw_pkg::OP_WRITE: if (ok) shadow_screen[int'(y) * NCOL + int'(x)] = {a, c};
         tcw_pkg::OP_READ: begin
            if (ok) {r.attr, r.ch} = shadow_screen[int'(y) * NCOL + int'(x)];
            else {r.attr, r.ch} = {tcw_pkg::DEFAULT_ATTR, tcw_pkg::BLANK_CHAR};
         end
         default: ;
      endcase
      r.col = 7'(cur_col);
      r.row = 5'(cur_row);
      r.lin = 11'(cur_row * NCOL + cur_col);
      return r;
   endfunction

   // ---- drivers ----
   task automatic send_cmd(logic [3:0] f, logic [7:0] c, logic [7:0] x, logic [7:0] y,
                           logic [7:0] a);
      int gap;
      gap = $urandom_range(0, 3);
      // idle between transactions, or keep start high for a back-to-back one
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_char_code <= c;
      req_col_x <= x;
      req_row_y <= y;
      req_cell_attr <= a;
      // hold until the transaction is taken
      do @(posedge clock); while (busy);
      expected_rsp.push_back(console_predict(f, c, x, y, a));
      cmd_count++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_attr(logic [7:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_text_attr <= v;
      do @(posedge clock); while (!csr_ready);
      cur_attr = v;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(int pct_put);
      logic [3:0] f;
      logic [7:0] x, y;
      int         p;
      p = $urandom_range(0, 99);
      // text by the given percentage, cursor and cell work otherwise, rare full-store passes
      if (p < pct_put) f = tcw_pkg::OP_PUT;
      else if (p < 97) f = 4'($urandom_range(1, 15));
      else f = 4'($urandom_range(tcw_pkg::OP_CLEAR, tcw_pkg::OP_SDN));
      if (p >= pct_put && p < 97 &&
          (f == tcw_pkg::OP_CLEAR || f == tcw_pkg::OP_SUP || f == tcw_pkg::OP_SDN))
         f = tcw_pkg::OP_READ;
      x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NCOL - 1));
      y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NROW - 1));
      send_cmd(f, ($urandom_range(0, 7) == 0) ? tcw_pkg::NEWLINE_CHAR : 8'($urandom), x, y,
               8'($urandom));
   endtask

   // ---- response checker ----
   always @(posedge clock) begin
      rsp_t got, exp_r;
      if (!reset && rsp_valid) begin
         got = {rsp_cell_char, rsp_cell_attr_out, rsp_cursor_col, rsp_cursor_row,
                rsp_cursor_linear};
         rsp_count++;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            err_count++;
         end else begin
            exp_r = expected_rsp.pop_front();
            if (got.ch !== exp_r.ch || got.attr !== exp_r.attr || got.col !== exp_r.col ||
                got.row !== exp_r.row || got.lin !== exp_r.lin) begin
               $display("%0t: mismatch exp ch=%h at=%h col=%0d row=%0d lin=%0d",
                        $time, exp_r.ch, exp_r.attr, exp_r.col, exp_r.row, exp_r.lin);
               $display("%0t:          got ch=%h at=%h col=%0d row=%0d lin=%0d",
                        $time, got.ch, got.attr, got.col, got.row, got.lin);
               err_count++;
            end
         end
      end
   end

   // ---- tests ----
   task automatic test_directed();
      send_cmd(tcw_pkg::OP_BKSP, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_LEFT, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_UP, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_PUT, 8'hFF, 0, 0, 0);
      send_cmd(tcw_pkg::OP_PUT, 8'h00, 0, 0, 0);
      send_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 0, 0, 0);
      send_cmd(tcw_pkg::OP_READ, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_SET, 0, 8'(NCOL - 1), 8'(NROW - 1), 0);
      send_cmd(tcw_pkg::OP_RIGHT, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_DOWN, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_PUT, 8'h41, 0, 0, 0);
      send_cmd(tcw_pkg::OP_SET, 0, 8'(NCOL), 0, 0);
      send_cmd(tcw_pkg::OP_SET, 0, 0, 8'hFF, 0);
      send_cmd(tcw_pkg::OP_WRITE, 8'hFF, 8'(NCOL - 1), 0, 8'hFF);
      send_cmd(tcw_pkg::OP_WRITE, 8'h55, 8'hFF, 8'hFF, 8'hAA);
      send_cmd(tcw_pkg::OP_READ, 0, 8'(NCOL - 1), 0, 0);
      send_cmd(tcw_pkg::OP_READ, 0, 8'hFF, 8'hFF, 8'hFF);
      send_cmd(tcw_pkg::OP_SET, 0, 0, 1, 0);
      send_cmd(tcw_pkg::OP_BKSP, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_SUP, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_SDN, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_READ, 0, 8'(NCOL - 1), 1, 0);
      send_cmd(OP_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_cmd(tcw_pkg::OP_CLEAR, 0, 0, 0, 0);
      send_cmd(tcw_pkg::OP_READ, 0, 0, 8'(NROW - 1), 0);
   endtask

   task automatic test_random_text(int n);
      for (int i = 0; i < n; i++) send_random(60);
   endtask

   task automatic test_attr_sweep();
      logic [7:0] vals [4] = '{8'h00, 8'hFF, 8'h1E, 8'hF0};
      foreach (vals[k]) begin
         write_attr(vals[k]);
         for (int i = 0; i < 60; i++) send_random(45);
         send_cmd(tcw_pkg::OP_SUP, 0, 0, 0, 0);
      end
   endtask

   initial begin
      cur_attr = tcw_pkg::DEFAULT_ATTR;
      cur_col = 0;
      cur_row = 0;
      for (int i = 0; i < NCELL; i++)
         shadow_screen[i] = {tcw_pkg::DEFAULT_ATTR, tcw_pkg::BLANK_CHAR};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_attr(8'h4F);
      test_random_text(250);
      // sender holds off until the console has caught up
      drain();
      test_attr_sweep();
      write_attr(tcw_pkg::DEFAULT_ATTR);
      test_random_text(230);
      drain();
      repeat (SCROLL_CYC + 20) @(posedge clock);
      $display("Sent %0d commands, checked %0d responses over six attribute settings",
               cmd_count, rsp_count);
      if (err_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
